/* design/gsstep_pkg.sv */
// Shared package for the Gray-Scott grid step unit: grid geometry, line buffer
// sizing, fixed-point widths, register codes, controller states and payload types.
// No dependencies.
`timescale 1ns / 1ps

package gsstep_pkg;

  // Grid geometry
  localparam int unsigned GRID_WIDTH  = 32;
  localparam int unsigned GRID_HEIGHT = 32;
  localparam int unsigned COL_W       = $clog2(GRID_WIDTH);
  localparam int unsigned ROW_W       = $clog2(GRID_HEIGHT);

  // Line buffer: two rows plus two cells, rounded up to a power of two
  localparam int unsigned LB_DEPTH  = 2 ** $clog2(2 * GRID_WIDTH + 2);
  localparam int unsigned LB_ADDR_W = $clog2(LB_DEPTH);

  // Fixed-point widths
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned CELL_W = 2 * VAL_W;
  localparam int unsigned LAP_W  = 19;
  localparam int unsigned SUM_W  = 52;

  localparam logic [VAL_W-1:0] ONE_Q15 = 16'h8000;

  // Distance back from the newest cell to each stencil neighbor
  localparam logic [LB_ADDR_W-1:0] DIST_L  = LB_ADDR_W'(GRID_WIDTH + 2);
  localparam logic [LB_ADDR_W-1:0] DIST_C  = LB_ADDR_W'(GRID_WIDTH + 1);
  localparam logic [LB_ADDR_W-1:0] DIST_R  = LB_ADDR_W'(GRID_WIDTH);
  localparam logic [LB_ADDR_W-1:0] DIST_UP = LB_ADDR_W'(2 * GRID_WIDTH + 1);

  // Configuration registers
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_U = 2'd0,
    CFG_DIFF_V = 2'd1,
    CFG_FEED   = 2'd2,
    CFG_KILL   = 2'd3
  } cfg_reg_e;

  localparam logic [VAL_W-1:0] DIFF_U_RST = 16'd10486;
  localparam logic [VAL_W-1:0] DIFF_V_RST = 16'd5243;
  localparam logic [VAL_W-1:0] FEED_RST   = 16'd2425;
  localparam logic [VAL_W-1:0] KILL_RST   = 16'd3932;

  typedef enum logic [1:0] {
    TAP_L,
    TAP_C,
    TAP_R,
    TAP_UP
  } tap_e;

  localparam int unsigned TAP_NUM = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_L,
    ST_RD_C,
    ST_RD_R,
    ST_RD_UP,
    ST_RD_WAIT,
    ST_LAP,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_EMIT,
    ST_BORDER
  } state_e;

  typedef struct packed {
    logic [VAL_W-1:0] cell_u;
    logic [VAL_W-1:0] cell_v;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] new_u;
    logic [VAL_W-1:0] new_v;
    logic             frame_end;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic in_fire;
    logic rd_en;
    tap_e rd_sel;
    logic lap_en;
    logic mul1_en;
    logic mul2_en;
    logic sum_en;
    logic out_load;
    logic out_border;
    logic out_frame_end;
  } cmd_t;

  // Round half up from scale 2^45 to Q1.15 and clamp to 0..65535
  function automatic logic [VAL_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    logic [VAL_W-1:0] r;
    t = $unsigned(s) + (SUM_W'(1) << 29);
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (|t[SUM_W-1:30+VAL_W]) begin
      r = '1;
    end else begin
      r = t[30+VAL_W-1:30];
    end
    return r;
  endfunction

endpackage

/* design/gsstep_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gsstep_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/gsstep_ctrl.sv */
// Controller for the grid step unit: raster position, emit decisions,
// per-cell sequencing of the datapath and the output valid flag. Uses gsstep_pkg.
`timescale 1ns / 1ps

module gsstep_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                frame_start_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output gsstep_pkg::cmd_t    cmd_o
);

  localparam int unsigned COL_W = gsstep_pkg::COL_W;
  localparam int unsigned ROW_W = gsstep_pkg::ROW_W;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(gsstep_pkg::GRID_WIDTH - 1);
  localparam logic [COL_W-1:0] MX_MAX   = COL_W'(gsstep_pkg::GRID_WIDTH - 2);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(gsstep_pkg::GRID_HEIGHT - 1);
  localparam logic [ROW_W-1:0] MY_MAX   = ROW_W'(gsstep_pkg::GRID_HEIGHT - 2);

  gsstep_pkg::state_e state_q, state_d;
  logic [COL_W-1:0] col_q, col_d, cnt_q, cnt_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             last_q, last_d;
  logic             border_q, border_d;
  logic             out_valid_q, out_valid_d;

  logic [COL_W-1:0] col_eff, mx;
  logic [ROW_W-1:0] row_eff, my;
  logic             emit, interior, is_last, slot_free, fire;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == gsstep_pkg::ST_IDLE);
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Position of the incoming cell and of the lagged cell it completes
  always_comb begin
    col_eff  = frame_start_i ? '0 : col_q;
    row_eff  = frame_start_i ? '0 : row_q;
    emit     = (row_eff >= ROW_W'(2)) || (row_eff == ROW_W'(1) && col_eff != '0);
    if (col_eff != '0) begin
      mx = col_eff - COL_W'(1);
      my = row_eff - ROW_W'(1);
    end else begin
      mx = COL_LAST;
      my = row_eff - ROW_W'(2);
    end
    interior = emit && my >= ROW_W'(1) && my <= MY_MAX && mx >= COL_W'(1) && mx <= MX_MAX;
    is_last  = (row_eff == ROW_LAST) && (col_eff == COL_LAST);
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    last_d   = last_q;
    border_d = border_q;
    if (fire) begin
      last_d   = is_last;
      border_d = !interior;
      if (col_eff == COL_LAST) begin
        col_d = '0;
        row_d = (row_eff == ROW_LAST) ? '0 : row_eff + ROW_W'(1);
      end else begin
        col_d = col_eff + COL_W'(1);
        row_d = row_eff;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (state_q == gsstep_pkg::ST_EMIT) begin
      cnt_d = '0;
    end else if (state_q == gsstep_pkg::ST_BORDER && slot_free) begin
      cnt_d = cnt_q + COL_W'(1);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gsstep_pkg::ST_IDLE: begin
        if (fire) begin
          if (interior) begin
            state_d = gsstep_pkg::ST_RD_L;
          end else if (emit) begin
            state_d = gsstep_pkg::ST_EMIT;
          end
        end
      end
      gsstep_pkg::ST_RD_L:    state_d = gsstep_pkg::ST_RD_C;
      gsstep_pkg::ST_RD_C:    state_d = gsstep_pkg::ST_RD_R;
      gsstep_pkg::ST_RD_R:    state_d = gsstep_pkg::ST_RD_UP;
      gsstep_pkg::ST_RD_UP:   state_d = gsstep_pkg::ST_RD_WAIT;
      gsstep_pkg::ST_RD_WAIT: state_d = gsstep_pkg::ST_LAP;
      gsstep_pkg::ST_LAP:     state_d = gsstep_pkg::ST_MUL1;
      gsstep_pkg::ST_MUL1:    state_d = gsstep_pkg::ST_MUL2;
      gsstep_pkg::ST_MUL2:    state_d = gsstep_pkg::ST_SUM;
      gsstep_pkg::ST_SUM:     state_d = gsstep_pkg::ST_EMIT;
      gsstep_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = last_q ? gsstep_pkg::ST_BORDER : gsstep_pkg::ST_IDLE;
        end
      end
      gsstep_pkg::ST_BORDER: begin
        if (slot_free && cnt_q == COL_LAST) begin
          state_d = gsstep_pkg::ST_IDLE;
        end
      end
      default: state_d = gsstep_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = gsstep_pkg::TAP_L;
    unique case (state_q)
      gsstep_pkg::ST_IDLE:  cmd_o.in_fire = fire;
      gsstep_pkg::ST_RD_L: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = gsstep_pkg::TAP_L;
      end
      gsstep_pkg::ST_RD_C: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = gsstep_pkg::TAP_C;
      end
      gsstep_pkg::ST_RD_R: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = gsstep_pkg::TAP_R;
      end
      gsstep_pkg::ST_RD_UP: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = gsstep_pkg::TAP_UP;
      end
      gsstep_pkg::ST_RD_WAIT: ;
      gsstep_pkg::ST_LAP:     cmd_o.lap_en  = 1'b1;
      gsstep_pkg::ST_MUL1:    cmd_o.mul1_en = 1'b1;
      gsstep_pkg::ST_MUL2:    cmd_o.mul2_en = 1'b1;
      gsstep_pkg::ST_SUM:     cmd_o.sum_en  = 1'b1;
      gsstep_pkg::ST_EMIT: begin
        cmd_o.out_load   = slot_free;
        cmd_o.out_border = border_q;
      end
      gsstep_pkg::ST_BORDER: begin
        cmd_o.out_load      = slot_free;
        cmd_o.out_border    = 1'b1;
        cmd_o.out_frame_end = (cnt_q == COL_LAST);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gsstep_pkg::ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      border_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      border_q    <= border_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* design/gsstep_dp.sv */
// Datapath for the grid step unit: configuration registers, line buffer,
// stencil taps, Laplacian, reaction terms, rounding and the output register.
// Uses gsstep_pkg and gsstep_ram.
`timescale 1ns / 1ps

module gsstep_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gsstep_pkg::cmd_t                     cmd_i,
  input  gsstep_pkg::in_item_t                 in_data_i,
  output gsstep_pkg::out_item_t                out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [gsstep_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gsstep_pkg::VAL_W-1:0]         cfg_data_i
);

  localparam int unsigned VAL_W  = gsstep_pkg::VAL_W;
  localparam int unsigned CELL_W = gsstep_pkg::CELL_W;
  localparam int unsigned AW     = gsstep_pkg::LB_ADDR_W;
  localparam int unsigned LAP_W  = gsstep_pkg::LAP_W;
  localparam int unsigned SUM_W  = gsstep_pkg::SUM_W;

  // Configuration
  logic [VAL_W-1:0] du_q, dv_q, f_q, k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      du_q <= gsstep_pkg::DIFF_U_RST;
      dv_q <= gsstep_pkg::DIFF_V_RST;
      f_q  <= gsstep_pkg::FEED_RST;
      k_q  <= gsstep_pkg::KILL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gsstep_pkg::CFG_DIFF_U: du_q <= cfg_data_i;
        gsstep_pkg::CFG_DIFF_V: dv_q <= cfg_data_i;
        gsstep_pkg::CFG_FEED:   f_q  <= cfg_data_i;
        gsstep_pkg::CFG_KILL:   k_q  <= cfg_data_i;
      endcase
    end
  end

  // Line buffer and its write pointer
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  assign wr_ptr_d = wr_ptr_q + AW'(1);
  assign wdata    = {in_data_i.cell_v, in_data_i.cell_u};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
    end else if (cmd_i.in_fire) begin
      wr_ptr_q <= wr_ptr_d;
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      gsstep_pkg::TAP_L:  raddr = wr_ptr_q - gsstep_pkg::DIST_L;
      gsstep_pkg::TAP_C:  raddr = wr_ptr_q - gsstep_pkg::DIST_C;
      gsstep_pkg::TAP_R:  raddr = wr_ptr_q - gsstep_pkg::DIST_R;
      gsstep_pkg::TAP_UP: raddr = wr_ptr_q - gsstep_pkg::DIST_UP;
    endcase
  end

  gsstep_ram #(
    .WIDTH(CELL_W),
    .DEPTH(gsstep_pkg::LB_DEPTH)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.in_fire),
    .waddr_i(wr_ptr_d),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Capture the registered read data under a delayed valid and tag; keep the cell below in registers
  logic              rd_vld_q;
  gsstep_pkg::tap_e  rd_tag_q;
  logic [CELL_W-1:0] tap_q [gsstep_pkg::TAP_NUM];
  logic [CELL_W-1:0] prev_q, dn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_tag_q <= gsstep_pkg::TAP_L;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_tag_q <= cmd_i.rd_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      tap_q[rd_tag_q] <= rdata;
    end
    if (cmd_i.in_fire) begin
      dn_q   <= prev_q;
      prev_q <= wdata;
    end
  end

  logic [VAL_W-1:0] c_u, c_v;
  assign c_u = tap_q[gsstep_pkg::TAP_C][VAL_W-1:0];
  assign c_v = tap_q[gsstep_pkg::TAP_C][CELL_W-1:VAL_W];

  // Laplacian stage
  logic [LAP_W-2:0]        sum4_u, sum4_v;
  logic signed [LAP_W-1:0] lap_u_q, lap_v_q;

  assign sum4_u = (LAP_W-1)'(tap_q[gsstep_pkg::TAP_L][VAL_W-1:0])
                + (LAP_W-1)'(tap_q[gsstep_pkg::TAP_R][VAL_W-1:0])
                + (LAP_W-1)'(tap_q[gsstep_pkg::TAP_UP][VAL_W-1:0])
                + (LAP_W-1)'(dn_q[VAL_W-1:0]);
  assign sum4_v = (LAP_W-1)'(tap_q[gsstep_pkg::TAP_L][CELL_W-1:VAL_W])
                + (LAP_W-1)'(tap_q[gsstep_pkg::TAP_R][CELL_W-1:VAL_W])
                + (LAP_W-1)'(tap_q[gsstep_pkg::TAP_UP][CELL_W-1:VAL_W])
                + (LAP_W-1)'(dn_q[CELL_W-1:VAL_W]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lap_en) begin
      lap_u_q <= $signed({1'b0, sum4_u}) - $signed({1'b0, c_u, 2'b00});
      lap_v_q <= $signed({1'b0, sum4_v}) - $signed({1'b0, c_v, 2'b00});
    end
  end

  // First products
  logic signed [VAL_W:0]   one_minus_u;
  logic [VAL_W:0]          f_plus_k;
  logic signed [35:0]      dulap_q, dvlap_q;
  logic signed [33:0]      fu_q;
  logic [32:0]             fkv_q;
  logic [CELL_W-1:0]       uv_q;

  assign one_minus_u = $signed({1'b0, gsstep_pkg::ONE_Q15}) - $signed({1'b0, c_u});
  assign f_plus_k    = (VAL_W+1)'(f_q) + (VAL_W+1)'(k_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1_en) begin
      dulap_q <= $signed({1'b0, du_q}) * lap_u_q;
      dvlap_q <= $signed({1'b0, dv_q}) * lap_v_q;
      fu_q    <= $signed({1'b0, f_q}) * one_minus_u;
      fkv_q   <= 33'(f_plus_k) * 33'(c_v);
      uv_q    <= CELL_W'(c_u) * CELL_W'(c_v);
    end
  end

  // Second product and partial sums at scale 2^45
  logic [47:0]             uvv_q;
  logic signed [SUM_W-1:0] part_u_q, part_v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2_en) begin
      uvv_q    <= 48'(uv_q) * 48'(c_v);
      part_u_q <= $signed({6'd0, c_u, 30'd0})
                + $signed({{2{dulap_q[35]}}, dulap_q, 14'd0})
                + $signed({{4{fu_q[33]}}, fu_q, 14'd0});
      part_v_q <= $signed({6'd0, c_v, 30'd0})
                + $signed({{2{dvlap_q[35]}}, dvlap_q, 14'd0})
                - $signed({5'd0, fkv_q, 14'd0});
    end
  end

  logic signed [SUM_W-1:0] su_q, sv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      su_q <= part_u_q - $signed({4'd0, uvv_q});
      sv_q <= part_v_q + $signed({4'd0, uvv_q});
    end
  end

  // Output register
  gsstep_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_border) begin
        out_q.new_u <= gsstep_pkg::ONE_Q15;
        out_q.new_v <= '0;
      end else begin
        out_q.new_u <= gsstep_pkg::round_sat(su_q);
        out_q.new_v <= gsstep_pkg::round_sat(sv_q);
      end
      out_q.frame_end <= cmd_i.out_frame_end;
    end
  end

  assign out_data_o = out_q;

endmodule

/* design/gray_scott_grid_step_unit.sv */
// Top level of the Gray-Scott grid step unit: controller plus datapath.
// Uses gsstep_pkg, gsstep_ctrl and gsstep_dp.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------
//   in      | in_valid_i/in_ready_o | in_data_i: cell_u, cell_v, frame_start
//   out     | out_valid_o/out_ready_i | out_data_o: new_u, new_v, frame_end
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i (always ready)
//
// From acceptance to the output register, an interior cell passes one write,
// four line buffer reads through the single read port, a read wait, the
// Laplacian, two multiply steps and the final sum; a border cell goes to emit.
// The last cell of a frame adds GRID_WIDTH border transactions. A stalled
// output holds the controller in its emit or border step; reset restores
// position, write pointer and configuration, and the line buffer needs no clear.
`timescale 1ns / 1ps

module gray_scott_grid_step_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  gsstep_pkg::in_item_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output gsstep_pkg::out_item_t                out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gsstep_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gsstep_pkg::VAL_W-1:0]         cfg_data_i
);

  gsstep_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  gsstep_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .frame_start_i(in_data_i.frame_start),
    .in_ready_o   (in_ready_o),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .cmd_o        (cmd)
  );

  gsstep_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // The frame end always falls on a bottom border cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |->
      out_data_o.new_u == gsstep_pkg::ONE_Q15 && out_data_o.new_v == '0)
    else $error("frame end on a cell that is not a border cell");

  // Hold a waiting result unchanged until its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("waiting result dropped or changed before transaction");

  // Output register is only reloaded when its content has been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !out_valid_o || out_ready_i)
    else $error("output register overwritten before transaction");

endmodule

/* tb/gsstep_checker.sv */
// Checker for the Gray-Scott grid step unit: watches the cell, result and register
// channels, predicts every result of each accepted cell and compares them in order.
// Depends on gsstep_pkg for geometry, register codes and payload types.
`timescale 1ns / 1ps

module gsstep_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  gsstep_pkg::in_item_t             in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  gsstep_pkg::out_item_t            out_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [gsstep_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gsstep_pkg::VAL_W-1:0]     cfg_data_i,
  output int                               mismatches_o,
  output int                               pending_o
);

  import gsstep_pkg::*;

  localparam int unsigned FRAME_CELLS = GRID_WIDTH * GRID_HEIGHT;

  logic [VAL_W-1:0]     diff_u_q, diff_v_q, feed_q, kill_q;
  logic [CELL_W-1:0]    cell_hist [LB_DEPTH];
  logic [LB_ADDR_W-1:0] hist_ptr;
  int unsigned          col_cnt, row_cnt;
  out_item_t            result_q [$];
  int                   mismatch_cnt;
  int                   pending_cnt;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  function automatic logic [CELL_W-1:0] tap(input logic [LB_ADDR_W-1:0] back);
    logic [LB_ADDR_W-1:0] addr;
    addr = hist_ptr - back;
    return cell_hist[addr];
  endfunction

  // Round half up from scale 2^45 down to Q1.15, then clamp
  function automatic logic [VAL_W-1:0] round_clamp(input longint sum);
    longint q;
    if (sum < 0) return '0;
    q = (sum + (64'sd1 <<< 29)) >>> 30;
    if (q > 65535) return 16'hFFFF;
    return VAL_W'(q);
  endfunction

  task automatic gray_scott_update(output logic [VAL_W-1:0] nu, output logic [VAL_W-1:0] nv);
    logic [CELL_W-1:0] c, l, r, up, dn;
    longint u, v, lap_u, lap_v, uvv, su, sv;
    c  = tap(DIST_C);
    l  = tap(DIST_L);
    r  = tap(DIST_R);
    up = tap(DIST_UP);
    dn = tap(LB_ADDR_W'(1));
    u  = longint'(c[VAL_W-1:0]);
    v  = longint'(c[CELL_W-1:VAL_W]);
    lap_u = longint'(l[VAL_W-1:0]) + longint'(r[VAL_W-1:0])
          + longint'(up[VAL_W-1:0]) + longint'(dn[VAL_W-1:0]) - 4 * u;
    lap_v = longint'(l[CELL_W-1:VAL_W]) + longint'(r[CELL_W-1:VAL_W])
          + longint'(up[CELL_W-1:VAL_W]) + longint'(dn[CELL_W-1:VAL_W]) - 4 * v;
    uvv = u * v * v;
    su = (u <<< 30) + longint'(diff_u_q) * lap_u * 16384 - uvv
       + longint'(feed_q) * (longint'(ONE_Q15) - u) * 16384;
    sv = (v <<< 30) + longint'(diff_v_q) * lap_v * 16384 + uvv
       - (longint'(feed_q) + longint'(kill_q)) * v * 16384;
    nu = round_clamp(su);
    nv = round_clamp(sv);
  endtask

  task automatic predict_cell(input in_item_t item);
    int unsigned pos, m, mx, my, x;
    out_item_t   res;
    logic [VAL_W-1:0] nu, nv;
    if (item.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    hist_ptr = hist_ptr + LB_ADDR_W'(1);
    cell_hist[hist_ptr] = {item.cell_v, item.cell_u};
    pos = row_cnt * GRID_WIDTH + col_cnt;
    if (pos >= GRID_WIDTH + 1) begin
      m  = pos - GRID_WIDTH - 1;
      my = m / GRID_WIDTH;
      mx = m % GRID_WIDTH;
      res.new_u = ONE_Q15;
      res.new_v = '0;
      res.frame_end = 1'b0;
      if (my >= 1 && my + 2 <= GRID_HEIGHT && mx >= 1 && mx + 2 <= GRID_WIDTH) begin
        gray_scott_update(nu, nv);
        res.new_u = nu;
        res.new_v = nv;
      end
      result_q.push_back(res);
    end
    // last cell of the frame also flushes the bottom border row
    if (pos == FRAME_CELLS - 1) begin
      for (x = 0; x < GRID_WIDTH; x++) begin
        res.new_u = ONE_Q15;
        res.new_v = '0;
        res.frame_end = (x == GRID_WIDTH - 1);
        result_q.push_back(res);
      end
    end
    col_cnt++;
    if (col_cnt >= GRID_WIDTH) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= GRID_HEIGHT) row_cnt = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      diff_u_q = DIFF_U_RST;
      diff_v_q = DIFF_V_RST;
      feed_q   = FEED_RST;
      kill_q   = KILL_RST;
      hist_ptr = '0;
      col_cnt  = 0;
      row_cnt  = 0;
      result_q.delete();
      mismatch_cnt = 0;
      pending_cnt  = 0;
    end else begin
      // compare first: a result can never stem from a cell accepted at the same edge
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result u=%h v=%h fe=%b", $realtime,
                     out_data_i.new_u, out_data_i.new_v, out_data_i.frame_end);
        end else begin
          want = result_q.pop_front();
          if (want.new_u !== out_data_i.new_u || want.new_v !== out_data_i.new_v ||
              want.frame_end !== out_data_i.frame_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: expected u=%h v=%h fe=%b, got u=%h v=%h fe=%b", $realtime,
                       want.new_u, want.new_v, want.frame_end,
                       out_data_i.new_u, out_data_i.new_v, out_data_i.frame_end);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_DIFF_U: diff_u_q = cfg_data_i;
          CFG_DIFF_V: diff_v_q = cfg_data_i;
          CFG_FEED:   feed_q   = cfg_data_i;
          CFG_KILL:   kill_q   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_cell(in_data_i);
      pending_cnt = result_q.size();
    end
  end

endmodule

/* tb/tb_gray_scott_grid_step_unit.sv */
// Top of the Gray-Scott grid step unit testbench: clock, reset, cell stimulus,
// register writes and output back-pressure. Uses gsstep_pkg, gsstep_checker and the block.
`timescale 1ns / 1ps

module tb_gray_scott_grid_step_unit;

  import gsstep_pkg::*;

  localparam int SETTLE_CYCLES    = 16;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT      = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;
  int                   mismatches;
  int                   pending;
  bit                   tail_no_idle = 1'b0;
  bit                   rx_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gray_scott_grid_step_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gsstep_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  function automatic logic [VAL_W-1:0] corner_value(input int k);
    case (k % 6)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return ONE_Q15;
      3:       return 16'h7FFF;
      4:       return 16'h0001;
      default: return 16'hFFFE;
    endcase
  endfunction

  // favor the rails and 1.0 so that saturation gets hit often
  function automatic logic [VAL_W-1:0] rand_conc();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return ONE_Q15;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_cell(input in_item_t item);
    if (!tail_no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input int cells, input bit restart, input bit noisy);
    int       i;
    in_item_t item;
    for (i = 0; i < cells; i++) begin
      item.cell_u = rand_conc();
      item.cell_v = rand_conc();
      item.frame_start = (i == 0 && restart) ||
                         (noisy && i > 0 && $urandom_range(0, 119) == 0);
      send_cell(item);
    end
  endtask

  // drop valid and wait out every owed result plus the block's own latency
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input logic [VAL_W-1:0] du, input logic [VAL_W-1:0] dv,
                            input logic [VAL_W-1:0] feed, input logic [VAL_W-1:0] kill);
    logic [VAL_W-1:0] vals [4];
    int               i;
    vals[CFG_DIFF_U] = du;
    vals[CFG_DIFF_V] = dv;
    vals[CFG_FEED]   = feed;
    vals[CFG_KILL]   = kill;
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // receiver: random stall bursts, one long hold on request, none in the tail
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else if (!tail_no_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int       i;
    int       waited;
    in_item_t item;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner concentrations at reset rates, with an early restart mid-frame
    for (i = 0; i < 24; i++) begin
      item.cell_u = corner_value(i);
      item.cell_v = corner_value(i + i / 6);
      item.frame_start = (i == 0) || (i == 15);
      send_cell(item);
    end

    // reset rates; results back up behind a long receiver hold
    rx_hold_req = 1'b1;
    send_frame(100, 1'b1, 1'b0);
    drain();

    // later blocks continue the frame, some with random restarts, so interior cells dominate
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(40, 1'b0, 1'b1);
    drain();

    write_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_frame(30, 1'b0, 1'b1);
    drain();

    write_regs(VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
    send_frame(40, 1'b0, 1'b0);
    drain();

    write_regs(16'hFFFF, 16'h0000, VAL_W'($urandom_range(0, 8191)),
               VAL_W'($urandom_range(0, 8191)));
    tail_no_idle = 1'b1;
    send_frame(40, 1'b0, 1'b1);

    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
